// ===== hw/rtl/lmhp_pkg.sv =====
package lmhp_pkg;

    // Longest frame the position counter tracks before it saturates
    localparam int MAX_FRAME_LEN = 256;
    localparam int POS_W         = $clog2(MAX_FRAME_LEN + 1);

    // Result queue depth; one end-of-frame byte may push two results
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    // Result kinds
    localparam logic [1:0] KIND_OPTION  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    // FPort value reported when the frame carries no port byte
    localparam logic [8:0] PORT_ABSENT = 9'd256;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       end_of_frame;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  item_kind;
        logic [7:0]  data_byte;
        logic        frame_error;
        logic [2:0]  message_type;
        logic [2:0]  reserved_bits;
        logic [1:0]  major_version;
        logic [31:0] device_address;
        logic [3:0]  control_flags;
        logic [3:0]  options_length;
        logic [15:0] frame_counter;
        logic [8:0]  port_number;
        logic [31:0] integrity_code;
    } out_item_t;

    // Results produced by one accepted byte, in delivery order
    typedef struct packed {
        logic [1:0] count;
        out_item_t  first;
        out_item_t  second;
    } res_pair_t;

endpackage

// ===== hw/rtl/lmhp_parser.sv =====
module lmhp_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  lmhp_pkg::in_item_t  in_item,
    output lmhp_pkg::res_pair_t results
);
    import lmhp_pkg::*;

    // Per-frame state
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       dly_reg [4];
    logic [7:0]       dly_next [4];
    logic [7:0]       mhdr_reg, mhdr_next;
    logic [31:0]      addr_reg, addr_next;
    logic [7:0]       fctrl_reg, fctrl_next;
    logic [15:0]      fcnt_reg, fcnt_next;
    logic [8:0]       port_reg, port_next;

    logic [POS_W-1:0] port_pos;
    logic [POS_W-1:0] short_lim;
    logic [7:0]       leaving;
    logic             past_header;
    logic             stream_hit;
    out_item_t        stream_item;
    out_item_t        summary_item;

    // Header capture, delay line and byte classification
    always_comb begin
        pos_next   = pos_reg;
        mhdr_next  = mhdr_reg;
        addr_next  = addr_reg;
        fctrl_next = fctrl_reg;
        fcnt_next  = fcnt_reg;
        port_next  = port_reg;

        if (pos_reg == POS_W'(0)) begin
            mhdr_next = in_item.frame_byte;
        end
        for (int k = 0; k < 4; k++) begin
            if (pos_reg == POS_W'(k + 1)) begin
                addr_next[8*k +: 8] = addr_reg[8*k +: 8] | in_item.frame_byte;
            end
        end
        if (pos_reg == POS_W'(5)) begin
            fctrl_next = in_item.frame_byte;
        end
        if (pos_reg == POS_W'(6)) begin
            fcnt_next[7:0] = in_item.frame_byte;
        end
        if (pos_reg == POS_W'(7)) begin
            fcnt_next[15:8] = in_item.frame_byte;
        end

        leaving     = dly_reg[0];
        dly_next[0] = dly_reg[1];
        dly_next[1] = dly_reg[2];
        dly_next[2] = dly_reg[3];
        dly_next[3] = in_item.frame_byte;

        // Leaving byte sits at pos - 4; FPort at 8 + FOptsLen
        port_pos    = POS_W'(12) + POS_W'(fctrl_next[3:0]);
        short_lim   = POS_W'(11) + POS_W'(fctrl_next[3:0]);
        past_header = (pos_reg >= POS_W'(12));
        stream_hit  = past_header && (pos_reg != port_pos);
        if (past_header && (pos_reg == port_pos)) begin
            port_next = {1'b0, leaving};
        end

        if (pos_reg < POS_W'(MAX_FRAME_LEN)) begin
            pos_next = pos_reg + POS_W'(1);
        end

        stream_item           = '0;
        stream_item.item_kind = (pos_reg < port_pos) ? KIND_OPTION : KIND_PAYLOAD;
        stream_item.data_byte = leaving;

        summary_item                = '0;
        summary_item.item_kind      = KIND_SUMMARY;
        summary_item.frame_error    = (pos_reg < short_lim);
        summary_item.message_type   = mhdr_next[7:5];
        summary_item.reserved_bits  = mhdr_next[4:2];
        summary_item.major_version  = mhdr_next[1:0];
        summary_item.device_address = addr_next;
        summary_item.control_flags  = fctrl_next[7:4];
        summary_item.options_length = fctrl_next[3:0];
        summary_item.frame_counter  = fcnt_next;
        summary_item.port_number    = port_next;
        summary_item.integrity_code = {dly_next[3], dly_next[2], dly_next[1], dly_next[0]};

        // Pack the results in order: streamed byte first, summary last
        results = '0;
        if (accept) begin
            if (stream_hit && in_item.end_of_frame) begin
                results.count  = 2'd2;
                results.first  = stream_item;
                results.second = summary_item;
            end else if (stream_hit) begin
                results.count = 2'd1;
                results.first = stream_item;
            end else if (in_item.end_of_frame) begin
                results.count = 2'd1;
                results.first = summary_item;
            end
        end
    end

    // Frame state; cleared by reset and after the end byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            mhdr_reg  <= '0;
            addr_reg  <= '0;
            fctrl_reg <= '0;
            fcnt_reg  <= '0;
            port_reg  <= PORT_ABSENT;
            for (int k = 0; k < 4; k++) begin
                dly_reg[k] <= '0;
            end
        end else if (accept) begin
            if (in_item.end_of_frame) begin
                pos_reg   <= '0;
                mhdr_reg  <= '0;
                addr_reg  <= '0;
                fctrl_reg <= '0;
                fcnt_reg  <= '0;
                port_reg  <= PORT_ABSENT;
                for (int k = 0; k < 4; k++) begin
                    dly_reg[k] <= '0;
                end
            end else begin
                pos_reg   <= pos_next;
                mhdr_reg  <= mhdr_next;
                addr_reg  <= addr_next;
                fctrl_reg <= fctrl_next;
                fcnt_reg  <= fcnt_next;
                port_reg  <= port_next;
                for (int k = 0; k < 4; k++) begin
                    dly_reg[k] <= dly_next[k];
                end
            end
        end
    end

endmodule

// ===== hw/rtl/lmhp_out_queue.sv =====
module lmhp_out_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lmhp_pkg::res_pair_t  push,
    output logic                 has_room,
    output logic                 m_valid,
    input  logic                 m_ready,
    output lmhp_pkg::out_item_t  m_data
);
    import lmhp_pkg::*;

    out_item_t         mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              pop;

    // Room for two results keeps the input side free of the output stall
    assign has_room = (count_reg <= QCNT_W'(QUEUE_DEPTH - 2));
    assign m_valid  = (count_reg != '0);
    assign m_data   = mem[rd_ptr_reg];
    assign pop      = m_valid && m_ready;

    always_comb begin
        count_next = count_reg + QCNT_W'(push.count) - QCNT_W'(pop);
    end

    // Storage, written one or two entries per transfer
    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            mem[wr_ptr_reg + QPTR_W'(1)] <= push.second;
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + QPTR_W'(push.count);
            rd_ptr_reg <= rd_ptr_reg + QPTR_W'(pop);
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hw/rtl/lorawan_mac_header_parser.sv =====
// LoRaWAN MAC header parser. Takes one frame byte per transfer on s_ (with
// end_of_frame on the last byte) and can accept a byte every cycle while the
// queue has room. Option and payload bytes come out on m_ four bytes behind
// the input, and the frame summary (MHDR fields, DevAddr, FCtrl, FCnt, FPort
// or 256, MIC and an error flag for frames shorter than 12 + FOptsLen)
// follows the end byte; discard a frame's streamed bytes when its summary
// flags an error. Results pass through a four-entry queue drained at one
// result per cycle while m_ready is high, so the output port sets the
// sustained rate: one byte per cycle, with the end byte of a frame also
// adding its summary as an extra result. A byte is taken while the queue
// holds at most two results. No start-up pass is needed after reset.
module lorawan_mac_header_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  lmhp_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output lmhp_pkg::out_item_t m_data
);
    import lmhp_pkg::*;

    res_pair_t results;
    logic      has_room;
    logic      accept;

    assign s_ready = has_room;
    assign accept  = s_valid && s_ready;

    // Frame decode
    lmhp_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .in_item (s_data),
        .results (results)
    );

    // Result queue and output port
    lmhp_out_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (results),
        .has_room (has_room),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    // Results appear only for an accepted byte
    a_push_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |-> (results.count == 2'd0))
        else $error("results pushed without an input transfer");

    // The summary is always last and only one per byte
    a_summary_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (results.count == 2'd2) |->
            (results.second.item_kind == KIND_SUMMARY &&
             results.first.item_kind != KIND_SUMMARY))
        else $error("summary not last in a result pair");

    // The end byte always yields a summary
    a_eof_summary: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.end_of_frame) |->
            (results.count == 2'd2 ||
             (results.count == 2'd1 && results.first.item_kind == KIND_SUMMARY)))
        else $error("end of frame without summary");

    // Input only stalls while results are waiting
    a_stall_has_output: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with empty queue");

endmodule

// ===== tb/sv/mac_frame_check_pkg.sv =====
`timescale 1ns / 100ps

package mac_frame_check_pkg;

    import lmhp_pkg::*;

    class mac_frame_scoreboard;

        // Per-frame decode state, kept in step with the parser
        int unsigned byte_pos;
        logic [7:0]  window [4];
        logic [7:0]  mhdr;
        logic [31:0] dev_addr;
        logic [7:0]  fctrl;
        logic [15:0] fcnt;
        logic [8:0]  fport;

        out_item_t   awaited_items [$];
        int          errors;

        function new();
            errors = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            byte_pos = 0;
            foreach (window[i]) window[i] = 8'h00;
            mhdr     = 8'h00;
            dev_addr = 32'h0;
            fctrl    = 8'h00;
            fcnt     = 16'h0;
            fport    = PORT_ABSENT;
        endfunction

        function int pending();
            return awaited_items.size();
        endfunction

        // Decode one accepted frame byte and queue the results it causes
        function void note_byte(in_item_t it);
            logic [7:0]  b;
            logic [7:0]  leaving;
            int unsigned opts;
            int unsigned opos;
            int unsigned frame_len;
            out_item_t   r;
            b       = it.frame_byte;
            leaving = window[0];

            // header capture by position
            if (byte_pos == 0)
                mhdr = b;
            else if (byte_pos <= 4)
                dev_addr[8 * (byte_pos - 1) +: 8] = b;
            else if (byte_pos == 5)
                fctrl = b;
            else if (byte_pos == 6)
                fcnt[7:0] = b;
            else if (byte_pos == 7)
                fcnt[15:8] = b;
            opts = fctrl[3:0];

            // four-byte delay line
            window[0] = window[1];
            window[1] = window[2];
            window[2] = window[3];
            window[3] = b;

            // byte leaving the line: option, port or payload
            if (byte_pos >= 4) begin
                opos = byte_pos - 4;
                if (opos >= 8) begin
                    if (opos == 8 + opts) begin
                        fport = {1'b0, leaving};
                    end else begin
                        r           = '0;
                        r.item_kind = (opos < 8 + opts) ? KIND_OPTION : KIND_PAYLOAD;
                        r.data_byte = leaving;
                        awaited_items.push_back(r);
                    end
                end
            end

            frame_len = byte_pos + 1;
            if (byte_pos < MAX_FRAME_LEN)
                byte_pos++;

            // end of frame: summary, then a fresh frame
            if (it.end_of_frame) begin
                r                = '0;
                r.item_kind      = KIND_SUMMARY;
                r.frame_error    = (frame_len < 12 + opts);
                r.message_type   = mhdr[7:5];
                r.reserved_bits  = mhdr[4:2];
                r.major_version  = mhdr[1:0];
                r.device_address = dev_addr;
                r.control_flags  = fctrl[7:4];
                r.options_length = fctrl[3:0];
                r.frame_counter  = fcnt;
                r.port_number    = fport;
                r.integrity_code = {window[3], window[2], window[1], window[0]};
                awaited_items.push_back(r);
                clear_frame();
            end
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            end
        endfunction

        // Compare one accepted result with the oldest expectation
        function void check_result(out_item_t got);
            out_item_t want;
            if (awaited_items.size() == 0) begin
                errors++;
                $display("%0t: result kind %0d byte %0h with none expected (expected none)",
                         $time, got.item_kind, got.data_byte);
                return;
            end
            want = awaited_items.pop_front();
            compare_field("item_kind", want.item_kind, got.item_kind);
            compare_field("data_byte", want.data_byte, got.data_byte);
            compare_field("frame_error", want.frame_error, got.frame_error);
            compare_field("message_type", want.message_type, got.message_type);
            compare_field("reserved_bits", want.reserved_bits, got.reserved_bits);
            compare_field("major_version", want.major_version, got.major_version);
            compare_field("device_address", want.device_address, got.device_address);
            compare_field("control_flags", want.control_flags, got.control_flags);
            compare_field("options_length", want.options_length, got.options_length);
            compare_field("frame_counter", want.frame_counter, got.frame_counter);
            compare_field("port_number", want.port_number, got.port_number);
            compare_field("integrity_code", want.integrity_code, got.integrity_code);
        endfunction

    endclass

endpackage

// ===== tb/sv/tb_lorawan_mac_header_parser.sv =====
`timescale 1ns / 100ps

module tb_lorawan_mac_header_parser;

    import lmhp_pkg::*;
    import mac_frame_check_pkg::*;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    int        sent;

    mac_frame_scoreboard sb = new();

    lorawan_mac_header_parser DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    // Hard stop in case the block hangs
    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

    // Watch both channels; every transfer goes to the scoreboard
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_byte(s_data);
            if (m_valid && m_ready)
                sb.check_result(m_data);
        end
    end

    // One byte: optional idle gap, then hold valid until the transfer
    task automatic send_byte(input in_item_t it, input int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Whole frame; fill < 0 gives random bytes, FCtrl always at byte 5
    task automatic send_frame(input int len, input logic [7:0] ctrl, input int fill);
        in_item_t it;
        bit       calm;
        calm = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < len; i++) begin
            it.frame_byte   = (fill < 0) ? 8'($urandom) : fill[7:0];
            if (i == 5)
                it.frame_byte = ctrl;
            it.end_of_frame = (i == len - 1);
            send_byte(it, calm ? 0 : $urandom_range(0, 11));
            sent++;
        end
    endtask

    // Result side: random stalls, calm stretches, one long hold-off
    initial begin
        int  taken;
        bit  calm;
        int  stall;
        taken = 0;
        calm  = 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (taken == 30) begin
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
            end
            if (taken % 16 == 0)
                calm = ($urandom_range(0, 3) == 0);
            stall = calm ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            taken++;
        end
    end

    // Stimulus and end of run
    initial begin
        int         sel;
        int         len;
        logic [7:0] ctrl;
        bit         long_done;
        long_done = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // single all-ones byte: short frame, almost nothing captured
        send_frame(1, 8'hFF, 255);
        // eleven zero bytes: one short of header plus MIC
        send_frame(11, 8'h00, 0);
        // one option byte, port, one payload byte, all flags set
        send_frame(15, 8'hF1, 255);

        // Random frames: mostly well formed, some short, one overlong
        sent = 0;
        while (sent < 550) begin
            ctrl = 8'($urandom);
            sel  = $urandom_range(0, 9);
            if (!long_done && sent > 200) begin
                len       = MAX_FRAME_LEN + $urandom_range(1, 4);
                long_done = 1'b1;
            end else if (sel == 0)
                len = $urandom_range(1, 11 + ctrl[3:0]);
            else if (sel == 1)
                len = 12 + ctrl[3:0];
            else
                len = 12 + ctrl[3:0] + $urandom_range(1, 12);
            send_frame(len, ctrl, -1);
        end
        s_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
